FILE: sv/lz78_pkg.sv
// Shared types and constants for the LZ78 phrase decoder.
// Used by every module of the block but lz78_ram; depends on nothing else.
`timescale 1ns / 1ps

package lz78_pkg;

  // Dictionary and phrase limits.
  localparam int DICT_DEPTH = 4096;
  localparam int MAX_PHRASE = 64;

  // Field widths of the channels.
  localparam int INDEX_W = 16;
  localparam int BYTE_W  = 8;

  // Derived widths.
  localparam int LINK_W   = $clog2(DICT_DEPTH + 1);  // entry number 0..DICT_DEPTH
  localparam int ADDR_W   = $clog2(DICT_DEPTH);      // dictionary RAM address
  localparam int LEN_W    = $clog2(MAX_PHRASE + 1);  // phrase length 0..MAX_PHRASE
  localparam int STACK_AW = $clog2(MAX_PHRASE);      // phrase stack address

  // Queue between front and back.
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  // Result queue.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

  // Classified code pair handed from front to back.
  typedef struct packed {
    logic              beyond;     // index above any possible entry
    logic [LINK_W-1:0] idx;
    logic [BYTE_W-1:0] new_byte;
  } q_item_t;

  // One dictionary entry.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  len;
  } dict_entry_t;

  // One result waiting in the output queue.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    status_t           status;
  } out_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_LOOKUP,
    ST_LENGTH,
    ST_WALK,
    ST_COMMIT,
    ST_EMIT
  } back_state_t;

endpackage

FILE: sv/lz78_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module lz78_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/lz78_front.sv
// Front end: accepts code pairs, classifies the index and queues them for the back end.
// Depends on lz78_pkg.
`timescale 1ns / 1ps

module lz78_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [lz78_pkg::INDEX_W-1:0]   phrase_index,
  input  logic [lz78_pkg::BYTE_W-1:0]    new_byte,
  output logic                           q_valid,
  output lz78_pkg::q_item_t              q_item,
  input  logic                           q_pop
);

  lz78_pkg::q_item_t                   fq_mem [lz78_pkg::FQ_DEPTH];
  logic [lz78_pkg::FQ_PTR_W-1:0]       wptr;
  logic [lz78_pkg::FQ_PTR_W-1:0]       rptr;
  logic [lz78_pkg::FQ_CNT_W-1:0]       count;
  logic                                in_xfer;
  logic                                out_xfer;
  lz78_pkg::q_item_t                   classified;

  assign full     = (count == lz78_pkg::FQ_CNT_W'(lz78_pkg::FQ_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = fq_mem[rptr];
  assign in_xfer  = push && !full;
  assign out_xfer = q_pop && q_valid;

  // An index above the dictionary size can never name an entry.
  always_comb begin
    classified.beyond   = (phrase_index >
                           lz78_pkg::INDEX_W'(lz78_pkg::DICT_DEPTH));
    classified.idx      = phrase_index[lz78_pkg::LINK_W-1:0];
    classified.new_byte = new_byte;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fq_mem[wptr] <= classified;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (in_xfer) begin
        wptr <= (wptr == lz78_pkg::FQ_PTR_W'(lz78_pkg::FQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (out_xfer) begin
        rptr <= (rptr == lz78_pkg::FQ_PTR_W'(lz78_pkg::FQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + lz78_pkg::FQ_CNT_W'(in_xfer) - lz78_pkg::FQ_CNT_W'(out_xfer);
    end
  end

endmodule

FILE: sv/lz78_back.sv
// Back end: dictionary lookup, prefix chain walk, entry update and result queue.
// Depends on lz78_pkg and lz78_ram.
`timescale 1ns / 1ps

module lz78_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  lz78_pkg::q_item_t            q_item,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [lz78_pkg::BYTE_W-1:0]  out_byte,
  output logic                         last_of_phrase,
  output logic [1:0]                   status
);

  lz78_pkg::back_state_t               state;
  lz78_pkg::back_state_t               state_next;
  logic [lz78_pkg::LINK_W-1:0]         cur_idx;
  logic [lz78_pkg::LINK_W-1:0]         cur_idx_next;
  logic [lz78_pkg::BYTE_W-1:0]         cur_byte;
  logic [lz78_pkg::BYTE_W-1:0]         cur_byte_next;
  logic [lz78_pkg::LEN_W-1:0]          cur_len;
  logic [lz78_pkg::LEN_W-1:0]          cur_len_next;
  logic [lz78_pkg::STACK_AW-1:0]       pos;
  logic [lz78_pkg::STACK_AW-1:0]       pos_next;
  logic [lz78_pkg::STACK_AW-1:0]       emit_idx;
  logic [lz78_pkg::STACK_AW-1:0]       emit_idx_next;
  logic [lz78_pkg::LINK_W-1:0]         entry_count;
  logic [lz78_pkg::LINK_W-1:0]         entry_count_next;
  logic                                rd_pending;
  logic                                rd_last;
  logic                                rd_last_next;

  // Dictionary RAM port signals.
  logic                                dict_rd_en;
  logic [lz78_pkg::ADDR_W-1:0]         dict_rd_addr;
  lz78_pkg::dict_entry_t               dict_rd_data;
  logic                                dict_wr_en;
  logic [lz78_pkg::ADDR_W-1:0]         dict_wr_addr;
  lz78_pkg::dict_entry_t               dict_wr_data;

  // Phrase stack RAM port signals.
  logic                                stk_wr_en;
  logic [lz78_pkg::STACK_AW-1:0]       stk_wr_addr;
  logic [lz78_pkg::BYTE_W-1:0]         stk_wr_data;
  logic                                stk_rd_en;
  logic [lz78_pkg::STACK_AW-1:0]       stk_rd_addr;
  logic [lz78_pkg::BYTE_W-1:0]         stk_rd_data;

  // Result queue.
  lz78_pkg::out_item_t                 out_mem [lz78_pkg::OUT_DEPTH];
  logic [lz78_pkg::OUT_PTR_W-1:0]      out_wptr;
  logic [lz78_pkg::OUT_PTR_W-1:0]      out_rptr;
  logic [lz78_pkg::OUT_CNT_W-1:0]      out_count;
  logic                                out_push;
  logic                                out_pop;
  lz78_pkg::out_item_t                 out_push_data;
  lz78_pkg::out_item_t                 out_head;
  logic                                space_ok;
  logic                                err_push;
  lz78_pkg::status_t                   err_status;

  lz78_ram #(
    .WIDTH ($bits(lz78_pkg::dict_entry_t)),
    .DEPTH (lz78_pkg::DICT_DEPTH)
  ) u_dict (
    .clk     (clk),
    .wr_en   (dict_wr_en),
    .wr_addr (dict_wr_addr),
    .wr_data (dict_wr_data),
    .rd_en   (dict_rd_en),
    .rd_addr (dict_rd_addr),
    .rd_data (dict_rd_data)
  );

  lz78_ram #(
    .WIDTH (lz78_pkg::BYTE_W),
    .DEPTH (lz78_pkg::MAX_PHRASE)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  // Room for one more result, counting a stack read still in flight.
  assign space_ok = (out_count + lz78_pkg::OUT_CNT_W'(rd_pending)) <
                    lz78_pkg::OUT_CNT_W'(lz78_pkg::OUT_DEPTH);

  // Sequencer state register and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lz78_pkg::ST_LOOKUP;
      entry_count <= '0;
      rd_pending  <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      rd_pending  <= stk_rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_byte <= cur_byte_next;
    cur_len  <= cur_len_next;
    pos      <= pos_next;
    emit_idx <= emit_idx_next;
    rd_last  <= rd_last_next;
  end

  // Next state, RAM controls and error results.
  always_comb begin
    state_next       = state;
    cur_idx_next     = cur_idx;
    cur_byte_next    = cur_byte;
    cur_len_next     = cur_len;
    pos_next         = pos;
    emit_idx_next    = emit_idx;
    entry_count_next = entry_count;
    rd_last_next     = rd_last;
    q_pop            = 1'b0;
    dict_rd_en       = 1'b0;
    dict_rd_addr     = '0;
    dict_wr_en       = 1'b0;
    dict_wr_addr     = entry_count[lz78_pkg::ADDR_W-1:0];
    dict_wr_data     = '{link: cur_idx, data_byte: cur_byte, len: cur_len};
    stk_wr_en        = 1'b0;
    stk_wr_addr      = '0;
    stk_wr_data      = cur_byte;
    stk_rd_en        = 1'b0;
    stk_rd_addr      = emit_idx;
    err_push         = 1'b0;
    err_status       = lz78_pkg::STATUS_OK;

    unique case (state)
      // Take the next pair, check its index and start the prefix lookup.
      lz78_pkg::ST_LOOKUP: begin
        if (q_valid && !rd_pending) begin
          if (q_item.beyond || (q_item.idx > entry_count)) begin
            if (space_ok) begin
              err_push   = 1'b1;
              err_status = lz78_pkg::STATUS_BAD_INDEX;
              q_pop      = 1'b1;
            end
          end else begin
            q_pop         = 1'b1;
            cur_idx_next  = q_item.idx;
            cur_byte_next = q_item.new_byte;
            if (q_item.idx == '0) begin
              stk_wr_en    = 1'b1;
              stk_wr_addr  = '0;
              stk_wr_data  = q_item.new_byte;
              cur_len_next = lz78_pkg::LEN_W'(1);
              state_next   = lz78_pkg::ST_COMMIT;
            end else begin
              dict_rd_en   = 1'b1;
              dict_rd_addr = lz78_pkg::ADDR_W'(q_item.idx - lz78_pkg::LINK_W'(1));
              state_next   = lz78_pkg::ST_LENGTH;
            end
          end
        end
      end

      // Prefix entry is read: check the length and place the new byte at the end.
      lz78_pkg::ST_LENGTH: begin
        if (dict_rd_data.len >= lz78_pkg::LEN_W'(lz78_pkg::MAX_PHRASE)) begin
          if (space_ok) begin
            err_push   = 1'b1;
            err_status = lz78_pkg::STATUS_TOO_LONG;
            state_next = lz78_pkg::ST_LOOKUP;
          end
        end else begin
          cur_len_next = dict_rd_data.len + lz78_pkg::LEN_W'(1);
          stk_wr_en    = 1'b1;
          stk_wr_addr  = dict_rd_data.len[lz78_pkg::STACK_AW-1:0];
          stk_wr_data  = cur_byte;
          pos_next     = dict_rd_data.len[lz78_pkg::STACK_AW-1:0];
          state_next   = lz78_pkg::ST_WALK;
        end
      end

      // One link per cycle: store the entry byte and fetch its prefix.
      lz78_pkg::ST_WALK: begin
        stk_wr_en   = 1'b1;
        stk_wr_addr = pos - 1'b1;
        stk_wr_data = dict_rd_data.data_byte;
        pos_next    = pos - 1'b1;
        if (pos == lz78_pkg::STACK_AW'(1)) begin
          state_next = lz78_pkg::ST_COMMIT;
        end else begin
          dict_rd_en   = 1'b1;
          dict_rd_addr = lz78_pkg::ADDR_W'(dict_rd_data.link - lz78_pkg::LINK_W'(1));
        end
      end

      // Add the new phrase unless the dictionary is full.
      lz78_pkg::ST_COMMIT: begin
        if (entry_count < lz78_pkg::LINK_W'(lz78_pkg::DICT_DEPTH)) begin
          dict_wr_en       = 1'b1;
          entry_count_next = entry_count + lz78_pkg::LINK_W'(1);
        end
        emit_idx_next = '0;
        state_next    = lz78_pkg::ST_EMIT;
      end

      // Read the phrase out of the stack from its start, one byte per cycle while the result queue has room.
      lz78_pkg::ST_EMIT: begin
        if (space_ok) begin
          stk_rd_en     = 1'b1;
          emit_idx_next = emit_idx + 1'b1;
          rd_last_next  = ({1'b0, emit_idx} == (cur_len - lz78_pkg::LEN_W'(1)));
          if ({1'b0, emit_idx} == (cur_len - lz78_pkg::LEN_W'(1))) begin
            state_next = lz78_pkg::ST_LOOKUP;
          end
        end
      end

      default: begin
        state_next = lz78_pkg::ST_LOOKUP;
      end
    endcase
  end

  // Result queue input: stack data or an error result.
  assign out_push = rd_pending || err_push;

  always_comb begin
    if (rd_pending) begin
      out_push_data = '{data_byte: stk_rd_data, last: rd_last, status: lz78_pkg::STATUS_OK};
    end else begin
      out_push_data = '{data_byte: '0, last: 1'b1, status: err_status};
    end
  end

  assign empty          = (out_count == '0);
  assign out_pop        = pop && !empty;
  assign out_head       = out_mem[out_rptr];
  assign out_byte       = out_head.data_byte;
  assign last_of_phrase = out_head.last;
  assign status         = out_head.status;

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem[out_wptr] <= out_push_data;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr  <= '0;
      out_rptr  <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wptr <= (out_wptr == lz78_pkg::OUT_PTR_W'(lz78_pkg::OUT_DEPTH - 1)) ?
                    '0 : out_wptr + 1'b1;
      end
      if (out_pop) begin
        out_rptr <= (out_rptr == lz78_pkg::OUT_PTR_W'(lz78_pkg::OUT_DEPTH - 1)) ?
                    '0 : out_rptr + 1'b1;
      end
      out_count <= out_count + lz78_pkg::OUT_CNT_W'(out_push) -
                   lz78_pkg::OUT_CNT_W'(out_pop);
    end
  end

  // A stack read result and an error result never arrive in the same cycle.
  a_no_push_collision: assert property (@(posedge clk) disable iff (rst)
    !(rd_pending && err_push))
    else $error("stack data and error result pushed together");

  // The result queue is never written while full.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_count < lz78_pkg::OUT_CNT_W'(lz78_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  // The entry count never passes the dictionary size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= lz78_pkg::LINK_W'(lz78_pkg::DICT_DEPTH))
    else $error("entry count above dictionary size");

  // The chain walk continues until the first stack slot has been written.
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    (state == lz78_pkg::ST_WALK && pos != lz78_pkg::STACK_AW'(1)) |=>
    (state == lz78_pkg::ST_WALK))
    else $error("chain walk left early");

endmodule

FILE: sv/lz78_phrase_decoder_unit.sv
// Top level of the LZ78 phrase decoder: front end, back end and their queue.
// Depends on lz78_pkg, lz78_front, lz78_back and lz78_ram.
//
//   Channel   Handshake            Transfer when      Fields
//   input     push / full          push && !full      phrase_index, new_byte
//   result    empty / pop          pop && !empty      out_byte, last_of_phrase, status
//
// An item with a nonzero index and a phrase of L bytes passes in the back end through
// the lookup, the length check, one walk step per prefix link (L - 1), the commit and
// one read per byte out of the phrase stack. The next pair starts once the last byte
// has landed in the result queue. Index zero goes from the lookup straight to the
// commit; an error result ends the item at the lookup or at the length check. Reset is
// synchronous and clears counts and state; no clearing pass is needed. The front queue
// takes up to two pairs while the result queue waits on pop.
`timescale 1ns / 1ps

module lz78_phrase_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [lz78_pkg::INDEX_W-1:0]  phrase_index,
  input  logic [lz78_pkg::BYTE_W-1:0]   new_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [lz78_pkg::BYTE_W-1:0]   out_byte,
  output logic                          last_of_phrase,
  output logic [1:0]                    status
);

  logic               q_valid;
  logic               q_pop;
  lz78_pkg::q_item_t  q_item;

  lz78_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .phrase_index (phrase_index),
    .new_byte     (new_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  lz78_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .last_of_phrase (last_of_phrase),
    .status         (status)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the LZ78 phrase decoder unit.
// Drives code pairs through the push/full side, predicts every decoded byte and checks
// each pop/empty transfer against it. Depends on lz78_pkg and lz78_phrase_decoder_unit.
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 2 * lz78_pkg::MAX_PHRASE + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_PAIRS  = 48;

  typedef struct {
    logic [lz78_pkg::INDEX_W-1:0] idx;
    logic [lz78_pkg::BYTE_W-1:0]  nb;
  } code_pair_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [lz78_pkg::INDEX_W-1:0]  phrase_index = '0;
  logic [lz78_pkg::BYTE_W-1:0]   new_byte = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [lz78_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_of_phrase;
  logic [1:0]                    status;

  // Pairs waiting to be offered, and decoded bytes waiting to be popped.
  code_pair_t           pending_pairs[$];
  lz78_pkg::out_item_t  expected_bytes[$];

  // Dictionary as the predictor sees it, updated at each input transfer.
  logic [lz78_pkg::LINK_W-1:0]  dict_link [lz78_pkg::DICT_DEPTH];
  logic [lz78_pkg::BYTE_W-1:0]  dict_byte [lz78_pkg::DICT_DEPTH];
  logic [lz78_pkg::LEN_W-1:0]   dict_len  [lz78_pkg::DICT_DEPTH];
  int                           dict_count = 0;

  // Entry count and lengths as the stimulus generator plans them.
  int gen_len [lz78_pkg::DICT_DEPTH];
  int gen_count = 0;
  int long_entry = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int quiet_cycles = 0;

  lz78_phrase_decoder_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .phrase_index   (phrase_index),
    .new_byte       (new_byte),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .last_of_phrase (last_of_phrase),
    .status         (status)
  );

  always #5 clk = ~clk;

  // Queue one expected result.
  task automatic expect_byte(input logic [lz78_pkg::BYTE_W-1:0] b, input logic last,
                             input lz78_pkg::status_t st);
    lz78_pkg::out_item_t item;
    item.data_byte = b;
    item.last      = last;
    item.status    = st;
    expected_bytes.push_back(item);
  endtask

  // Decode one accepted pair: walk the prefix chain back, emit the phrase, grow the
  // dictionary.
  task automatic decode_pair(input logic [lz78_pkg::INDEX_W-1:0] idx,
                             input logic [lz78_pkg::BYTE_W-1:0] nb);
    logic [lz78_pkg::BYTE_W-1:0] phrase [lz78_pkg::MAX_PHRASE];
    int plen;
    int pos;
    int cur;
    if (int'(idx) > dict_count) begin
      expect_byte('0, 1'b1, lz78_pkg::STATUS_BAD_INDEX);
      return;
    end
    plen = (idx == 0) ? 1 : int'(dict_len[idx-1]) + 1;
    if (plen > lz78_pkg::MAX_PHRASE) begin
      expect_byte('0, 1'b1, lz78_pkg::STATUS_TOO_LONG);
      return;
    end
    pos = plen - 1;
    phrase[pos] = nb;
    cur = int'(idx);
    while (pos > 0 && cur != 0) begin
      pos--;
      phrase[pos] = dict_byte[cur-1];
      cur = int'(dict_link[cur-1]);
    end
    for (int k = 0; k < plen; k++) begin
      expect_byte(phrase[k], (k == plen - 1), lz78_pkg::STATUS_OK);
    end
    // A full dictionary keeps decoding but stops adding entries.
    if (dict_count < lz78_pkg::DICT_DEPTH) begin
      dict_link[dict_count] = idx[lz78_pkg::LINK_W-1:0];
      dict_byte[dict_count] = nb;
      dict_len[dict_count]  = lz78_pkg::LEN_W'(plen);
      dict_count++;
    end
  endtask

  // Queue a pair for the driver and track which entries it will create.
  task automatic plan_pair(input int idx, input logic [lz78_pkg::BYTE_W-1:0] nb);
    code_pair_t p;
    int plen;
    p.idx = lz78_pkg::INDEX_W'(idx);
    p.nb  = nb;
    pending_pairs.push_back(p);
    if (idx <= gen_count) begin
      plen = (idx == 0) ? 1 : gen_len[idx-1] + 1;
      if (plen <= lz78_pkg::MAX_PHRASE && gen_count < lz78_pkg::DICT_DEPTH) begin
        gen_len[gen_count] = plen;
        gen_count++;
      end
    end
  endtask

  // Mostly references to existing entries, with some empty prefixes, bad indexes
  // and references to the longest phrases.
  task automatic plan_random_pair();
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < 10 || gen_count == 0) begin
      idx = 0;
    end else if (r < 75) begin
      idx = $urandom_range(gen_count, 1);
    end else if (r < 85) begin
      idx = gen_count - $urandom_range((gen_count > 8) ? 7 : gen_count - 1, 0);
    end else if (r < 93) begin
      idx = $urandom_range(65535, gen_count + 1);
    end else if (long_entry != 0) begin
      idx = long_entry - $urandom_range(1, 0);
    end else begin
      idx = gen_count + 1;
    end
    plan_pair(idx, lz78_pkg::BYTE_W'($urandom_range(255)));
  endtask

  // Hold the sender until every queued pair is taken and every result has come.
  task automatic drain();
    while (pending_pairs.size() != 0 || push || expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Driver: offer the next pending pair, hold it while full is high.
  always @(posedge clk) begin : drive_proc
    code_pair_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_pair(phrase_index, new_byte);
      end
      if (!push || !full) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_pairs.pop_front();
          push         <= 1'b1;
          phrase_index <= nxt.idx;
          new_byte     <= nxt.nb;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and decide whether to pop next cycle.
  always @(posedge clk) begin : check_proc
    lz78_pkg::out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: byte=%h last=%b status=%0d",
                   $time, out_byte, last_of_phrase, status);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data_byte || last_of_phrase !== want.last ||
              status !== want.status) begin
            errors++;
            $display("%0t: mismatch: expected byte=%h last=%b status=%0d, %s",
                     $time, want.data_byte, want.last, want.status,
                     $sformatf("got byte=%h last=%b status=%0d",
                               out_byte, last_of_phrase, status));
          end
        end
      end
      // A requested hold-off keeps pop low for a long stretch.
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin : watchdog_proc
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim_proc
    int tip;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty prefix, byte extremes, newest entry, bad indexes.
    set_idling(0, 0);
    plan_pair(0, 8'hFF);
    plan_pair(1, 8'h00);
    plan_pair(2, 8'h80);
    plan_pair(0, 8'h00);
    plan_pair(gen_count, 8'h7F);
    plan_pair(gen_count + 1, 8'h55);
    plan_pair(16'hFFFF, 8'hFF);
    plan_pair(16'h8000, 8'h00);
    plan_pair(1, 8'h01);
    plan_pair(gen_count, 8'hFE);
    drain();

    // Phase 0, no idling: a long hold-off fills the block, then a chain up to the
    // longest phrase and one pair that would overflow it.
    hold_seq++;
    tip = 1;
    for (int i = 2; i <= lz78_pkg::MAX_PHRASE; i++) begin
      plan_pair(tip, lz78_pkg::BYTE_W'($urandom_range(255)));
      tip = gen_count;
    end
    long_entry = tip;
    plan_pair(long_entry, lz78_pkg::BYTE_W'($urandom_range(255)));
    plan_pair(long_entry - 1, lz78_pkg::BYTE_W'($urandom_range(255)));
    repeat (PHASE_PAIRS) plan_random_pair();
    drain();

    // Phases 1 to 3: sender idling, receiver stalling, then both.
    set_idling(57, 0);
    repeat (PHASE_PAIRS) plan_random_pair();
    drain();
    set_idling(0, 57);
    repeat (PHASE_PAIRS) plan_random_pair();
    drain();
    set_idling(14, 14);
    repeat (PHASE_PAIRS) plan_random_pair();
    drain();

    // Indexes at and just past the dictionary size, then a few more random pairs.
    plan_pair(lz78_pkg::DICT_DEPTH, lz78_pkg::BYTE_W'($urandom_range(255)));
    plan_pair(lz78_pkg::DICT_DEPTH + 1, lz78_pkg::BYTE_W'($urandom_range(255)));
    repeat (10) plan_random_pair();
    drain();

    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_bytes.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
